[src/sha256_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared constants, types and round functions for the byte-stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int WordW   = 32;
  localparam int BlkWords = 16;
  localparam int HashWords = 8;
  localparam int Rounds  = 64;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    r = '0;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam word_t KTab [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction
  function automatic word_t ssig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction
  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction
  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  // Request from the absorb front end to the compression core.
  typedef struct packed {
    logic start;
    logic finish;   // emit digest and reinit after this block
  } cmd_t;

endpackage
`default_nettype wire

[src/sha256_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for input bytes and digest words.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_byte;
  modport source (output valid, data_byte, has_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

[src/sha256_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sha256_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(Depth)-1:0] waddr,
  input  wire [Width-1:0]         wdata,
  input  wire [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]        rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/sha256_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs 64 rounds on the block in the block RAM, one round per cycle, keeps
// the hash in a RAM and streams out the digest on request.
// ----------------------------------------------------------------------------
module sha256_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire sha256_pkg::cmd_t cmd,
  output logic                 busy,
  // block RAM read port (words 0..15 of the block)
  output logic [3:0]           blk_raddr,
  input  wire  [31:0]          blk_rdata,
  sha256_out_if.source         dout
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ROUND, S_ADD, S_EMIT} state_t;
  state_t state;

  word_t a, b, c, d, e, f, g, h;
  word_t w [BlkWords];          // sliding 16-word schedule window
  logic [6:0] cnt;
  logic finish;

  // hash RAM
  logic       h_we;
  logic [2:0] h_waddr, h_raddr;
  word_t      h_wdata, h_rdata;
  logic       h_init;           // hash words read as initial values

  sha256_ram #(.Width(WordW), .Depth(HashWords)) u_hash (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata));

  word_t h_cur;
  logic [2:0] h_rd_q;
  assign h_cur = h_init ? init_hash(h_rd_q) : h_rdata;

  word_t wj, t1, t2, wnew;
  always_comb begin
    wj   = w[0];
    wnew = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
    t1   = h + bsig1(e) + ((e & f) ^ (~e & g)) + KTab[cnt[5:0]] + wj;
    t2   = bsig0(a) + ((a & b) ^ (a & c) ^ (b & c));
  end

  word_t sel_sum;
  always_comb begin
    case (h_rd_q)
      3'd0: sel_sum = a;
      3'd1: sel_sum = b;
      3'd2: sel_sum = c;
      3'd3: sel_sum = d;
      3'd4: sel_sum = e;
      3'd5: sel_sum = f;
      3'd6: sel_sum = g;
      default: sel_sum = h;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign blk_raddr = cnt[3:0];
  assign h_waddr = h_rd_q;
  assign h_wdata = h_cur + sel_sum;

  // Hash read address is issued the cycle before its word is used. While emitting it
  // follows h_rd_q and steps ahead on a take.
  always_comb begin
    if (state == S_LOAD) begin
      h_raddr = cnt[2:0] - 3'd1;
    end else if (state == S_EMIT) begin
      h_raddr = (dout.valid && dout.ready) ? h_rd_q + 3'd1 : h_rd_q;
    end else begin
      h_raddr = cnt[2:0];
    end
    h_we    = (state == S_ADD) && (cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      h_init     <= 1'b1;
      finish     <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            finish <= cmd.finish;
            cnt    <= 7'd1;
            state  <= S_LOAD;
          end else begin
            cnt <= '0;
          end
        end
        // cnt k (1..16) receives block word k-1; also preload working vars
        S_LOAD: begin
          w[15] <= blk_rdata;
          for (int i = 0; i < BlkWords - 1; i++) w[i] <= w[i+1];
          h_rd_q <= cnt[2:0] - 3'd1;
          if (cnt >= 7'd2 && cnt <= 7'd9) begin
            h <= h_cur; g <= h; f <= g; e <= f; d <= e; c <= d; b <= c; a <= b;
          end
          if (cnt == 7'd16) begin
            cnt   <= '0;
            state <= S_ROUND;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ROUND: begin
          h <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          for (int i = 0; i < BlkWords - 1; i++) w[i] <= w[i+1];
          w[15] <= wnew;
          if (cnt == 7'd63) begin
            cnt   <= '0;
            state <= S_ADD;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        // cnt 0 issues read 0; cnt 1..8 write word cnt-1
        S_ADD: begin
          h_rd_q <= cnt[2:0];
          if (cnt == 7'd8) begin
            h_init <= 1'b0;
            cnt    <= '0;
            state  <= finish ? S_EMIT : S_IDLE;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        // one read in flight; present word when output slot is free
        S_EMIT: begin
          if (dout.valid && dout.ready) begin
            dout.valid <= 1'b0;
            if (dout.last_word) begin
              h_init <= 1'b1;
              cnt    <= '0;
              state  <= S_IDLE;
            end
          end else if (!dout.valid && cnt[3] == 1'b0 && cnt != '0) begin
            dout.valid       <= 1'b1;
            dout.digest_word <= h_rdata;
            dout.word_index  <= h_rd_q;
            dout.last_word   <= (h_rd_q == 3'd7);
          end
          if (!dout.valid && !(cnt != '0)) begin
            h_rd_q <= '0;
            cnt    <= 7'd1;
          end else if (dout.valid && dout.ready && !dout.last_word) begin
            h_rd_q <= h_rd_q + 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/sha256_byte_stream_hasher_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 byte-stream hasher
// Packs bytes into 512-bit blocks in a RAM and hashes them.
// ----------------------------------------------------------------------------
// Usage:
//   din  : one item per message byte (has_byte), last_byte ends the message.
//   dout : eight digest words, index 0 first, last_word on index 7.
// A byte that does not complete a block does not stall the input. A full block
// stalls the input while the core starts, loads the 16 block words, runs the
// 64 rounds (one per cycle, set by the single round datapath) and updates the
// eight hash words. A last item then walks the padding into the block RAM one
// byte per cycle while the core is idle, runs one or two more compressions and
// emits the digest words from the hash RAM, one read per word; a stalled
// receiver holds the current word and the input waits until all eight words
// are taken.
// Reset (synchronous rst) loads the initial hash values, clears the bit count
// and the packing word; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top (
  input wire           clk,
  input wire           rst,
  sha256_in_if.sink    din,
  sha256_out_if.source dout
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_WAIT, F_PAD, F_LEN, F_DONE} fstate_t;
  fstate_t fs;

  logic [63:0] bit_count;
  logic [63:0] length;
  word_t       acc;          // word being packed
  logic        fin_pending;

  cmd_t  cmd;
  logic  core_busy;
  logic [3:0] blk_raddr;
  word_t blk_rdata;

  logic       b_we;
  logic [3:0] b_waddr;
  word_t      b_wdata;

  sha256_ram #(.Width(WordW), .Depth(BlkWords)) u_blk (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(blk_raddr), .rdata(blk_rdata));

  sha256_core u_core (
    .clk(clk), .rst(rst), .cmd(cmd), .busy(core_busy),
    .blk_raddr(blk_raddr), .blk_rdata(blk_rdata), .dout(dout));

  logic take;
  assign din.ready = (fs == F_IDLE) && !core_busy && !cmd.start;
  assign take      = din.valid && din.ready;

  // Byte insert into packing word.
  logic [1:0] bpos;
  word_t      acc_byte;
  logic [7:0] ins;
  logic       ins_en;
  assign bpos = bit_count[4:3];

  always_comb begin
    ins    = din.data_byte;
    ins_en = take && din.has_byte;
    if (fs == F_PAD) begin
      ins    = 8'h00;
      ins_en = !core_busy && !cmd.start;
    end else if (fs == F_WAIT) begin
      ins    = 8'h80;
      ins_en = !core_busy && !cmd.start;
    end
    case (bpos)
      2'd0: acc_byte = {ins, 24'h0};
      2'd1: acc_byte = {acc[31:24], ins, 16'h0};
      2'd2: acc_byte = {acc[31:16], ins, 8'h0};
      default: acc_byte = {acc[31:8], ins};
    endcase
  end

  logic [63:0] cnt_inc;
  assign cnt_inc = bit_count + 64'd8;

  logic len_wr, fin_wr;
  assign len_wr = (fs == F_LEN) && !core_busy && !cmd.start && !b_we;
  assign fin_wr = (fs == F_DONE) && !fin_pending;

  // Padding is walked one byte per cycle while the core is idle, through the
  // packing word; length words are written directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      fs          <= F_IDLE;
      bit_count   <= '0;
      acc         <= '0;
      fin_pending <= 1'b0;
      cmd         <= '0;
      b_we        <= 1'b0;
    end else begin
      b_we <= (ins_en && bpos == 2'd3) || len_wr || fin_wr;
      cmd  <= '{start: (ins_en && cnt_inc[8:0] == 9'd0) || fin_wr, finish: fin_wr};
      if (ins_en) begin
        acc       <= (bpos == 2'd3) ? '0 : acc_byte;
        bit_count <= cnt_inc;
        if (bpos == 2'd3) begin
          b_waddr <= bit_count[8:5];
          b_wdata <= acc_byte;
        end
      end
      unique case (fs)
        F_IDLE: begin
          if (take && din.last_byte) begin
            length <= din.has_byte ? cnt_inc : bit_count;
            fs     <= F_WAIT;
          end
        end
        // 0x80 may already land on the length boundary
        F_WAIT: begin
          if (ins_en) fs <= (cnt_inc[8:0] == 9'd448) ? F_LEN : F_PAD;
        end
        F_PAD: begin
          if (ins_en && cnt_inc[8:0] == 9'd448) fs <= F_LEN;
        end
        F_LEN: begin
          if (len_wr) begin
            b_waddr   <= 4'd14;
            b_wdata   <= length[63:32];
            fs        <= F_DONE;
          end
        end
        F_DONE: begin
          if (fin_wr) begin
            b_waddr   <= 4'd15;
            b_wdata   <= length[31:0];
            fin_pending <= 1'b1;
          end else if (!core_busy && !cmd.start && !dout.valid) begin
            // core returns to idle only after the last word is taken
            fin_pending <= 1'b0;
            bit_count   <= '0;
            fs          <= F_IDLE;
          end
        end
        default: fs <= F_IDLE;
      endcase
    end
  end

  // Assertions
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    core_busy |-> !din.ready) else $error("input taken during compression");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.ready) |=> (dout.valid && $stable(dout.digest_word)))
    else $error("digest word dropped while stalled");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.last_word) |-> (dout.word_index == 3'd7))
    else $error("last word index");
  a_pad_idle: assert property (@(posedge clk) disable iff (rst)
    (fs != F_IDLE) |-> !din.ready) else $error("input taken while padding");

endmodule
`default_nettype wire
